// File: hdl/ide_sector_read_port_unit_defines.svh
// ----------------------------------------------------------------------------
// IDE sector read port assertion macros
// Shared helpers for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef IDE_SECTOR_READ_PORT_UNIT_DEFINES_SVH
`define IDE_SECTOR_READ_PORT_UNIT_DEFINES_SVH

// Implication in the same cycle, ignored while reset is held.
`define ISRP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isrp port check failed");

// Implication into the following cycle, ignored while reset is held.
`define ISRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isrp port check failed");

// Implication into the following cycle that also covers the reset cycles.
`define ISRP_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("isrp reset check failed");

`endif

// File: hdl/isrp_pkg.sv
// ----------------------------------------------------------------------------
// isrp_pkg
// Types and constants shared by the IDE sector read port modules.
// ----------------------------------------------------------------------------
`default_nettype none

package isrp_pkg;

  // Request kinds.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;

  // Register offsets.
  localparam logic [3:0] REG_DATA      = 4'd0;
  localparam logic [3:0] REG_DATA_STEP = 4'd1;
  localparam logic [3:0] REG_COUNT     = 4'd2;
  localparam logic [3:0] REG_LBA_LOW   = 4'd3;
  localparam logic [3:0] REG_LBA_MID   = 4'd4;
  localparam logic [3:0] REG_LBA_HIGH  = 4'd5;
  localparam logic [3:0] REG_DRIVE     = 4'd6;
  localparam logic [3:0] REG_COMMAND   = 4'd7;

  localparam logic [7:0] STATUS_READY = 8'h50;
  localparam logic [7:0] UNUSED_READ  = 8'hFF;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] offset;
    logic [7:0] value;
    logic [8:0] fill_index;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        fetch_request;
    logic [23:0] fetch_lba;
    logic [7:0]  fetch_unit;
  } out_t;

  // Result in flight between the register stage and the output stage.
  // When sel_buf is set, read_data is taken from the buffer read port.
  typedef struct packed {
    logic sel_buf;
    out_t item;
  } stage_t;

endpackage

`default_nettype wire

// File: hdl/isrp_buffer.sv
// ----------------------------------------------------------------------------
// isrp_buffer
// Sector byte buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module isrp_buffer #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a stalled result keeps its byte.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/isrp_ctrl.sv
// ----------------------------------------------------------------------------
// isrp_ctrl
// Task-file registers, request decode and buffer access issue.
// ----------------------------------------------------------------------------
`default_nettype none

module isrp_ctrl #(
  parameter int SECTOR_BYTES = 512,
  parameter int AW           = 9
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire isrp_pkg::in_t      in_item,
  input  wire logic               s1_take,
  output logic                    s1_valid_r,
  output isrp_pkg::stage_t        s1_r,
  output logic                    buf_wr_en,
  output logic [AW-1:0]           buf_wr_addr,
  output logic [7:0]              buf_wr_data,
  output logic                    buf_rd_en,
  output logic [AW-1:0]           buf_rd_addr
);

  // Fill indexes are compared in a width that holds both the field and the depth.
  localparam int FW = ((AW > 9) ? AW : 9) + 1;

  logic [AW-1:0] pos_r,   pos_nxt;
  logic [7:0]    left_r,  left_nxt;
  logic [23:0]   lba_r,   lba_nxt;
  logic [7:0]    drive_r, drive_nxt;
  logic [7:0]    unit_r;
  isrp_pkg::stage_t s1_nxt;

  logic          accept;
  logic [AW:0]   pos_inc;
  logic          pos_wrap;
  logic [AW-1:0] pos_step;
  logic [7:0]    left_dec;
  logic [23:0]   lba_inc;
  logic [FW-1:0] fidx_ext;
  logic          fill_ok;

  assign in_ready = !s1_valid_r || s1_take;
  assign accept   = in_valid && in_ready;

  assign pos_inc  = {1'b0, pos_r} + (AW+1)'(1);
  assign pos_wrap = (pos_inc == (AW+1)'(SECTOR_BYTES));
  assign pos_step = pos_wrap ? '0 : pos_inc[AW-1:0];
  assign left_dec = left_r - 8'd1;
  assign lba_inc  = lba_r + 24'd1;
  assign fidx_ext = FW'(in_item.fill_index);
  assign fill_ok  = (fidx_ext < FW'(SECTOR_BYTES));

  assign buf_wr_addr = AW'(fidx_ext);
  assign buf_wr_data = in_item.value;
  assign buf_rd_addr = pos_r;

  always_comb begin
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    lba_nxt   = lba_r;
    drive_nxt = drive_r;
    s1_nxt    = '0;
    buf_wr_en = 1'b0;
    buf_rd_en = 1'b0;

    if (accept) begin
      unique case (in_item.action)
        isrp_pkg::ACT_WRITE: begin
          unique case (in_item.offset)
            isrp_pkg::REG_COUNT:    left_nxt  = in_item.value;
            isrp_pkg::REG_LBA_LOW:  lba_nxt   = {16'd0, in_item.value};
            isrp_pkg::REG_LBA_MID:  lba_nxt   = lba_r | {8'd0, in_item.value, 8'd0};
            isrp_pkg::REG_LBA_HIGH: lba_nxt   = lba_r | {in_item.value, 16'd0};
            isrp_pkg::REG_DRIVE:    drive_nxt = in_item.value;
            isrp_pkg::REG_COMMAND: begin
              pos_nxt                   = '0;
              s1_nxt.item.fetch_request = 1'b1;
              s1_nxt.item.fetch_lba     = lba_r;
              s1_nxt.item.fetch_unit    = unit_r;
            end
            default: ;
          endcase
        end
        isrp_pkg::ACT_READ: begin
          unique case (in_item.offset)
            isrp_pkg::REG_DATA: begin
              buf_rd_en      = 1'b1;
              s1_nxt.sel_buf = 1'b1;
              pos_nxt        = pos_step;
            end
            isrp_pkg::REG_DATA_STEP: begin
              buf_rd_en      = 1'b1;
              s1_nxt.sel_buf = 1'b1;
              pos_nxt        = pos_step;
              // At the sector end the count drops; a count left nonzero
              // (underflow included) moves on to the next block.
              if (pos_wrap) begin
                left_nxt = left_dec;
                if (left_dec != 8'd0) begin
                  lba_nxt                   = lba_inc;
                  s1_nxt.item.fetch_request = 1'b1;
                  s1_nxt.item.fetch_lba     = lba_inc;
                  s1_nxt.item.fetch_unit    = unit_r;
                end
              end
            end
            isrp_pkg::REG_COUNT:    s1_nxt.item.read_data = left_r;
            isrp_pkg::REG_LBA_LOW:  s1_nxt.item.read_data = lba_r[7:0];
            isrp_pkg::REG_LBA_MID:  s1_nxt.item.read_data = lba_r[15:8];
            isrp_pkg::REG_LBA_HIGH: s1_nxt.item.read_data = lba_r[23:16];
            isrp_pkg::REG_DRIVE:    s1_nxt.item.read_data = drive_r;
            isrp_pkg::REG_COMMAND:  s1_nxt.item.read_data = isrp_pkg::STATUS_READY;
            default:                s1_nxt.item.read_data = isrp_pkg::UNUSED_READ;
          endcase
        end
        isrp_pkg::ACT_FILL: begin
          buf_wr_en = fill_ok;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      left_r     <= '0;
      lba_r      <= '0;
      drive_r    <= '0;
      unit_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
      lba_r   <= lba_nxt;
      drive_r <= drive_nxt;
      if (cfg_we) begin
        unit_r <= cfg_data;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/isrp_out.sv
// ----------------------------------------------------------------------------
// isrp_out
// Output register: merges buffer read data into the result and holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module isrp_out (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s1_valid,
  input  wire isrp_pkg::stage_t  s1,
  input  wire logic [7:0]        buf_rd_data,
  output logic                   s1_take,
  output logic                   out_valid_r,
  input  wire logic              out_ready,
  output isrp_pkg::out_t         out_item_r
);

  isrp_pkg::out_t merged;

  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  always_comb begin
    merged = s1.item;
    if (s1.sel_buf) begin
      merged.read_data = buf_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_item_r <= merged;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ide_sector_read_port_unit.sv
// ----------------------------------------------------------------------------
// ide_sector_read_port_unit
// Byte-wide IDE task-file read port with a sector buffer and fetch requests.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Carries
//  in_      input      in_valid / in_ready   isrp_pkg::in_t request
//  out_     output     out_valid / out_ready isrp_pkg::out_t result
//  cfg_     input      cfg_valid / cfg_ready disc unit identifier
//
// One request is taken every cycle while in_ready is high; each gives exactly one
// result once accepted, through the register stage and then the output register.
// The sector buffer read port returns registered data, held by the buffer memory.
// Reset is synchronous on rst_n; the buffer holds no reset and needs no clear.
// A stalled output stops the register stage, and in_ready drops only when both
// stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module ide_sector_read_port_unit #(
  parameter int SECTOR_BYTES = 512
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [7:0]     cfg_data,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire isrp_pkg::in_t  in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output isrp_pkg::out_t      out_item
);

  localparam int AW = $clog2(SECTOR_BYTES);

  logic              s1_valid;
  isrp_pkg::stage_t  s1;
  logic              s1_take;
  logic              buf_wr_en;
  logic [AW-1:0]     buf_wr_addr;
  logic [7:0]        buf_wr_data;
  logic              buf_rd_en;
  logic [AW-1:0]     buf_rd_addr;
  logic [7:0]        buf_rd_data;

  assign cfg_ready = 1'b1;

  isrp_ctrl #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .AW           (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .s1_take     (s1_take),
    .s1_valid_r  (s1_valid),
    .s1_r        (s1),
    .buf_wr_en   (buf_wr_en),
    .buf_wr_addr (buf_wr_addr),
    .buf_wr_data (buf_wr_data),
    .buf_rd_en   (buf_rd_en),
    .buf_rd_addr (buf_rd_addr)
  );

  isrp_buffer #(
    .DEPTH (SECTOR_BYTES),
    .AW    (AW)
  ) u_buffer (
    .clk       (clk),
    .wr_en     (buf_wr_en),
    .wr_addr   (buf_wr_addr),
    .wr_data   (buf_wr_data),
    .rd_en     (buf_rd_en),
    .rd_addr   (buf_rd_addr),
    .rd_data_r (buf_rd_data)
  );

  isrp_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1          (s1),
    .buf_rd_data (buf_rd_data),
    .s1_take     (s1_take),
    .out_valid_r (out_valid),
    .out_ready   (out_ready),
    .out_item_r  (out_item)
  );

endmodule

`default_nettype wire

// File: hdl/isrp_checker.sv
// ----------------------------------------------------------------------------
// isrp_checker
// Port-level checks on the IDE sector read port, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ide_sector_read_port_unit_defines.svh"

module isrp_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire isrp_pkg::out_t out_item
);

  logic plain_result;
  logic fetch_fields_zero;

  assign plain_result      = out_valid && !out_item.fetch_request;
  assign fetch_fields_zero = (out_item.fetch_lba == 24'd0) && (out_item.fetch_unit == 8'd0);

  // A held result stays valid and unchanged.
  `ISRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

  // Without a fetch request the address and unit fields are zero.
  `ISRP_ASSERT_SAME(a_no_fetch_zero, plain_result, fetch_fields_zero)

  // Input back-pressure only comes from a full, stalled output.
  `ISRP_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready)

  // Reset leaves no result pending.
  `ISRP_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

endmodule

bind ide_sector_read_port_unit isrp_checker u_isrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
